// ----- hdl/hsv565_pkg.sv -----
// Shared types, constants and helpers for the HSV to RGB565 converter.
// No dependencies; used by hsv565_terms and hsv_to_rgb565_core.
package hsv565_pkg;

    // Sector codes: hue times six, integer part.
    localparam logic [2:0] SECTOR_0 = 3'd0;
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;

    localparam logic [7:0]  FULL_SCALE = 8'd255;
    // 255 in Q8.16, the scale that q and t numerators are measured against.
    localparam logic [23:0] FULL_Q16   = 24'hFF0000;
    localparam logic [18:0] HUE_SIX    = 19'd6;
    // ceil(2^24 / 255); exact floor division by 255 for any 16-bit dividend.
    localparam logic [16:0] RECIP_255  = 17'd65794;

    typedef struct packed {
        logic [2:0] sector;
        logic [7:0] v;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } terms_t;

    function automatic logic [7:0] div255(input logic [15:0] y);
        logic [32:0] prod;
        begin
            prod = {17'd0, y} * {16'd0, RECIP_255};
            return prod[31:24];
        end
    endfunction

endpackage

// ----- hdl/hsv565_terms.sv -----
// Four-stage datapath that turns hue, saturation and value into the sector
// number and the v, p, q and t channel terms. Depends on hsv565_pkg.
module hsv565_terms (
    input  logic                 clk,
    input  logic                 en,
    input  logic [15:0]          hue,
    input  logic [7:0]           saturation,
    input  logic [7:0]           brightness,
    output hsv565_pkg::terms_t   terms
);

    logic [18:0] hue_six;

    // Stage 1: sector and fraction, plus the p numerator.
    logic [2:0]  sector1_reg;
    logic [15:0] frac1_reg;
    logic [7:0]  sat1_reg;
    logic [7:0]  val1_reg;
    logic [15:0] pnum1_reg;

    // Stage 2: q and t numerators in Q8.16, p finished.
    logic [2:0]  sector2_reg;
    logic [7:0]  val2_reg;
    logic [7:0]  p2_reg;
    logic [23:0] qnum2_reg;
    logic [23:0] tnum2_reg;
    logic [23:0] fs_next;

    // Stage 3: numerators scaled by value, fraction bits dropped.
    logic [2:0]  sector3_reg;
    logic [7:0]  val3_reg;
    logic [7:0]  p3_reg;
    logic [15:0] qy3_reg;
    logic [15:0] ty3_reg;
    logic [31:0] qprod_next;
    logic [31:0] tprod_next;

    // Stage 4: final division by 255.
    hsv565_pkg::terms_t terms4_reg;

    assign hue_six    = {3'd0, hue} * hsv565_pkg::HUE_SIX;
    assign fs_next    = {8'd0, frac1_reg} * {16'd0, sat1_reg};
    assign qprod_next = {24'd0, val2_reg} * {8'd0, qnum2_reg};
    assign tprod_next = {24'd0, val2_reg} * {8'd0, tnum2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector1_reg <= hue_six[18:16];
            frac1_reg   <= hue_six[15:0];
            sat1_reg    <= saturation;
            val1_reg    <= brightness;
            pnum1_reg   <= {8'd0, brightness} *
                           {8'd0, hsv565_pkg::FULL_SCALE - saturation};

            sector2_reg <= sector1_reg;
            val2_reg    <= val1_reg;
            p2_reg      <= hsv565_pkg::div255(pnum1_reg);
            qnum2_reg   <= hsv565_pkg::FULL_Q16 - fs_next;
            // 255*65536 - (65536-f)*s is rewritten as (255-s)*65536 + f*s.
            tnum2_reg   <= {hsv565_pkg::FULL_SCALE - sat1_reg, 16'd0} + fs_next;

            sector3_reg <= sector2_reg;
            val3_reg    <= val2_reg;
            p3_reg      <= p2_reg;
            qy3_reg     <= qprod_next[31:16];
            ty3_reg     <= tprod_next[31:16];

            terms4_reg.sector <= sector3_reg;
            terms4_reg.v      <= val3_reg;
            terms4_reg.p      <= p3_reg;
            terms4_reg.q      <= hsv565_pkg::div255(qy3_reg);
            terms4_reg.t      <= hsv565_pkg::div255(ty3_reg);
        end
    end

    assign terms = terms4_reg;

endmodule

// ----- hdl/hsv_to_rgb565_core.sv -----
// HSV to RGB565 converter, top level. Depends on hsv565_pkg and hsv565_terms.
// A request runs through the hsv565_terms stages, then the pixel register.
// Throughput: one request per cycle; the whole pipeline holds while a
// finished pixel is stalled, so in_stall follows out_valid and out_stall.
// Reset clears all valid bits asynchronously; payload registers are not reset.
module hsv_to_rgb565_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel
);

    logic               en;
    logic [3:0]         vld_reg;
    logic               out_valid_reg;
    logic [15:0]        pixel_reg;
    logic [15:0]        pixel_next;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    hsv565_pkg::terms_t terms;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    hsv565_terms u_terms (
        .clk        (clk),
        .en         (en),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .terms      (terms)
    );

    always_comb
    begin
        case (terms.sector)
            hsv565_pkg::SECTOR_0:
            begin
                red = terms.v; green = terms.t; blue = terms.p;
            end
            hsv565_pkg::SECTOR_1:
            begin
                red = terms.q; green = terms.v; blue = terms.p;
            end
            hsv565_pkg::SECTOR_2:
            begin
                red = terms.p; green = terms.v; blue = terms.t;
            end
            hsv565_pkg::SECTOR_3:
            begin
                red = terms.p; green = terms.q; blue = terms.v;
            end
            hsv565_pkg::SECTOR_4:
            begin
                red = terms.t; green = terms.p; blue = terms.v;
            end
            default:
            begin
                red = terms.v; green = terms.p; blue = terms.q;
            end
        endcase
        pixel_next = {red[7:3], green[7:2], blue[7:3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[2:0], in_valid};
            out_valid_reg <= vld_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;

`ifndef ASSERT_OFF
    // An accepted request shows up as a pixel if the pipeline stays enabled.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 5) && $past(rst_n, 4) && $past(rst_n, 3) &&
        $past(rst_n, 2) && $past(rst_n, 1) &&
        $past(in_valid && !in_stall, 5) && $past(en, 4) && $past(en, 3) &&
        $past(en, 2) && $past(en, 1) |-> out_valid)
        else $error("accepted request did not reach the output in 5 cycles");

    // While the output is stalled, no item inside the pipeline moves.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(vld_reg))
        else $error("pipeline advanced while the output was stalled");

    // With no requests as all valid bits shift out, the pipeline drains empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1) &&
        !$past(in_valid, 4) && !$past(in_valid, 3) && !$past(in_valid, 2) &&
        !$past(in_valid, 1) && $past(en, 4) && $past(en, 3) && $past(en, 2) &&
        $past(en, 1) |-> vld_reg == 4'd0)
        else $error("pipeline holds a valid item that was never requested");
`endif

endmodule

// ----- tb/sv/hsv_to_rgb565_core_tb.sv -----
// Self-checking testbench for hsv_to_rgb565_core: directed colours, then random requests.
// Needs hsv565_pkg for the sector codes and the RTL of the converter, nothing else.
module hsv_to_rgb565_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM   = 1800;
    localparam int QUIET_TAIL   = 300;
    localparam int PRESSURE_AT  = 500;
    localparam int PRESSURE_LEN = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  sat;
        logic [7:0]  val;
        logic        known;
        logic [15:0] pixel;
    } colour_row_t;

    localparam int NUM_DIRECTED = 22;

    // Rows with known set carry a pixel that follows directly from the colour.
    colour_row_t directed_colours [NUM_DIRECTED] = '{
        '{16'h0000, 8'hFF, 8'hFF, 1'b1, 16'hF800},
        '{16'h0000, 8'h00, 8'h00, 1'b1, 16'h0000},
        '{16'hFFFF, 8'hFF, 8'h00, 1'b1, 16'h0000},
        '{16'h8000, 8'h7F, 8'h00, 1'b1, 16'h0000},
        '{16'h1234, 8'h00, 8'hFF, 1'b1, 16'hFFFF},
        '{16'hC0DE, 8'h00, 8'h80, 1'b1, 16'h8410},
        '{16'hFFFF, 8'h00, 8'hFF, 1'b1, 16'hFFFF},
        '{16'h2AAA, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'h2AAB, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'h5555, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'h5556, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'h8000, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'hAAAA, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'hAAAB, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'hD555, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'hD556, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'hFFFF, 8'hFF, 8'hFF, 1'b0, 16'h0000},
        '{16'h5555, 8'hAA, 8'h55, 1'b0, 16'h0000},
        '{16'hAAAA, 8'h55, 8'hAA, 1'b0, 16'h0000},
        '{16'h7FFF, 8'h01, 8'hFE, 1'b0, 16'h0000},
        '{16'h0001, 8'hFE, 8'h01, 1'b0, 16'h0000},
        '{16'h4000, 8'h80, 8'hC0, 1'b0, 16'h0000}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] pixel;

    logic [15:0] pending_pixels [$];
    int          requests_taken;
    int          mismatch_count;
    int          cycle_count;
    bit          quiet;

    hsv_to_rgb565_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel      (pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Six-sector HSV conversion with exact rational p, q and t terms, truncated.
    function automatic logic [15:0] rgb565_of(input logic [15:0] h, input logic [7:0] s,
                                              input logic [7:0] v);
        logic [18:0] turn6;
        logic [2:0]  sector;
        logic [15:0] frac;
        logic [39:0] unit;
        logic [39:0] q_num;
        logic [39:0] t_num;
        logic [7:0]  p_term;
        logic [7:0]  q_term;
        logic [7:0]  t_term;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        begin
            turn6  = {3'b000, h} * 19'd6;
            sector = turn6[18:16];
            frac   = turn6[15:0];
            unit   = 40'd255 * 40'd65536;
            q_num  = unit - 40'(frac) * 40'(s);
            t_num  = unit - (40'd65536 - 40'(frac)) * 40'(s);
            p_term = 8'((32'(v) * (32'd255 - 32'(s))) / 32'd255);
            q_term = 8'((40'(v) * q_num) / unit);
            t_term = 8'((40'(v) * t_num) / unit);
            case (sector)
                hsv565_pkg::SECTOR_0:
                begin
                    red = v;      green = t_term; blue = p_term;
                end
                hsv565_pkg::SECTOR_1:
                begin
                    red = q_term; green = v;      blue = p_term;
                end
                hsv565_pkg::SECTOR_2:
                begin
                    red = p_term; green = v;      blue = t_term;
                end
                hsv565_pkg::SECTOR_3:
                begin
                    red = p_term; green = q_term; blue = v;
                end
                hsv565_pkg::SECTOR_4:
                begin
                    red = t_term; green = p_term; blue = v;
                end
                default:
                begin
                    red = v;      green = p_term; blue = q_term;
                end
            endcase
            return {red[7:3], green[7:2], blue[7:3]};
        end
    endfunction

    task automatic offer_request(input logic [15:0] h, input logic [7:0] s, input logic [7:0] v,
                                 input bit known, input logic [15:0] known_pixel);
        int gap;
        begin
            gap = 0;
            if (!quiet && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 12);
            // While idle the payload carries noise that the block must ignore.
            repeat (gap)
            begin
                @(negedge clk);
                in_valid   <= 1'b0;
                hue        <= 16'($urandom());
                saturation <= 8'($urandom());
                brightness <= 8'($urandom());
            end
            @(negedge clk);
            in_valid   <= 1'b1;
            hue        <= h;
            saturation <= s;
            brightness <= v;
            forever
            begin
                @(posedge clk);
                if (!in_stall)
                    break;
            end
            pending_pixels.push_back(known ? known_pixel : rgb565_of(h, s, v));
            requests_taken++;
        end
    endtask

    initial
    begin
        logic [15:0] h;
        logic [7:0]  s;
        logic [7:0]  v;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        hue            = '0;
        saturation     = '0;
        brightness     = '0;
        requests_taken = 0;
        mismatch_count = 0;
        quiet          = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_colours[i])
            offer_request(directed_colours[i].hue, directed_colours[i].sat,
                          directed_colours[i].val, directed_colours[i].known,
                          directed_colours[i].pixel);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n >= NUM_RANDOM - QUIET_TAIL)
                quiet = 1'b1;
            h = 16'($urandom());
            s = 8'($urandom());
            v = 8'($urandom());
            case ($urandom_range(0, 11))
                0: s = 8'h00;
                1: v = 8'h00;
                2: s = 8'hFF;
                3: v = 8'hFF;
                // Land just around a sector boundary.
                4: h = 16'(($urandom_range(0, 5) * 65536) / 6 + $urandom_range(0, 2)) - 16'd1;
                default: ;
            endcase
            offer_request(h, s, v, 1'b0, 16'h0000);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("hsv_to_rgb565_core_tb: clean");
        else
            $display("hsv_to_rgb565_core_tb: errors");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off that backs up the pipeline,
    // and no stalls at all near the end.
    initial
    begin
        bit pressure_done;
        int burst;
        out_stall     = 1'b0;
        pressure_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!pressure_done && requests_taken >= PRESSURE_AT)
            begin
                out_stall <= 1'b1;
                repeat (PRESSURE_LEN) @(negedge clk);
                out_stall     <= 1'b0;
                pressure_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel: expected none, got %h", pixel);
                mismatch_count++;
            end
            else
            begin
                if (pixel !== pending_pixels[0])
                begin
                    $error("pixel: expected %h, got %h", pending_pixels[0], pixel);
                    mismatch_count++;
                end
                void'(pending_pixels.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hsv_to_rgb565_core_tb: errors");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
